// ===== rtl/iirlhp_pkg.sv =====
// ----------------------------------------------------------------------------
// iirlhp_pkg
// Shared types, widths and codes for the low-pass / high-pass IIR filter.
// ----------------------------------------------------------------------------
package iirlhp_pkg;

  // Depth of the output history and fractional bits of the coefficients.
  localparam int HISTORY_DEPTH  = 4;
  localparam int COEF_FRAC_BITS = 20;

  // Field widths.
  localparam int SAMPLE_W  = 16;
  localparam int COEF_W    = 24;
  localparam int HIST_FRAC = 8;
  localparam int HIST_W    = SAMPLE_W + HIST_FRAC;
  localparam int MODE_W    = 3;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = COEF_W;

  // Product and accumulator widths.
  localparam int PROD_W  = COEF_W + HIST_W;
  localparam int GPROD_W = COEF_W + SAMPLE_W;
  localparam int ACC_W   = PROD_W + 4;

  // Filter modes.
  typedef enum logic [MODE_W-1:0] {
    MODE_MUTE = 3'd0,
    MODE_LP1  = 3'd1,
    MODE_LP2  = 3'd2,
    MODE_LP3  = 3'd3,
    MODE_LP4  = 3'd4,
    MODE_HP1  = 3'd5,
    MODE_HP2  = 3'd6,
    MODE_PASS = 3'd7
  } mode_e;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE = 3'd0,
    REG_FB1  = 3'd1,
    REG_FB2  = 3'd2,
    REG_FB3  = 3'd3,
    REG_FB4  = 3'd4,
    REG_FF0  = 3'd5,
    REG_FF1  = 3'd6,
    REG_FF2  = 3'd7
  } cfg_idx_e;

  // Current configuration as seen by the datapath.
  typedef struct packed {
    mode_e                     mode;
    logic signed [COEF_W-1:0]  fb1;
    logic signed [COEF_W-1:0]  fb2;
    logic signed [COEF_W-1:0]  fb3;
    logic signed [COEF_W-1:0]  fb4;
    logic signed [COEF_W-1:0]  ff0;
    logic signed [COEF_W-1:0]  ff1;
    logic signed [COEF_W-1:0]  ff2;
  } cfg_t;

  // History taps read by the datapath.
  typedef struct packed {
    logic signed [HIST_W-1:0]   y1;
    logic signed [HIST_W-1:0]   y2;
    logic signed [HIST_W-1:0]   y3;
    logic signed [HIST_W-1:0]   y4;
    logic signed [SAMPLE_W-1:0] u1;
    logic signed [SAMPLE_W-1:0] u2;
  } taps_t;

endpackage

// ===== rtl/iirlhp_cfg.sv =====
// ----------------------------------------------------------------------------
// iirlhp_cfg
// Configuration register file: filter mode and the seven coefficients.
// ----------------------------------------------------------------------------
module iirlhp_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [iirlhp_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [iirlhp_pkg::CFG_W-1:0]  cfg_data_i,
  output iirlhp_pkg::cfg_t              cfg_o
);
  import iirlhp_pkg::*;

  cfg_t cfg_q;

  // Write one register per enabled cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{mode: MODE_PASS, default: '0};
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        REG_MODE: cfg_q.mode <= mode_e'(cfg_data_i[MODE_W-1:0]);
        REG_FB1:  cfg_q.fb1  <= cfg_data_i[COEF_W-1:0];
        REG_FB2:  cfg_q.fb2  <= cfg_data_i[COEF_W-1:0];
        REG_FB3:  cfg_q.fb3  <= cfg_data_i[COEF_W-1:0];
        REG_FB4:  cfg_q.fb4  <= cfg_data_i[COEF_W-1:0];
        REG_FF0:  cfg_q.ff0  <= cfg_data_i[COEF_W-1:0];
        REG_FF1:  cfg_q.ff1  <= cfg_data_i[COEF_W-1:0];
        REG_FF2:  cfg_q.ff2  <= cfg_data_i[COEF_W-1:0];
        default:  cfg_q      <= cfg_q;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/iirlhp_hist.sv =====
// ----------------------------------------------------------------------------
// iirlhp_hist
// Output and input history shift registers, cleared at reset.
// ----------------------------------------------------------------------------
module iirlhp_hist (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                push_i,
  input  logic signed [iirlhp_pkg::HIST_W-1:0]   y_i,
  input  logic signed [iirlhp_pkg::SAMPLE_W-1:0] x_i,
  output iirlhp_pkg::taps_t                   taps_o
);
  import iirlhp_pkg::*;

  logic signed [HIST_W-1:0]   yh_q [HISTORY_DEPTH];
  logic signed [SAMPLE_W-1:0] uh_q [2];

  // Shift both histories on every push; entry 0 is the newest.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
        yh_q[i] <= '0;
      end
      uh_q[0] <= '0;
      uh_q[1] <= '0;
    end else if (push_i) begin
      for (int i = HISTORY_DEPTH - 1; i > 0; i--) begin
        yh_q[i] <= yh_q[i-1];
      end
      yh_q[0] <= y_i;
      uh_q[1] <= uh_q[0];
      uh_q[0] <= x_i;
    end
  end

  // Only the four newest outputs feed the filter.
  assign taps_o.y1 = yh_q[0];
  assign taps_o.y2 = yh_q[1];
  assign taps_o.y3 = yh_q[2];
  assign taps_o.y4 = yh_q[3];
  assign taps_o.u1 = uh_q[0];
  assign taps_o.u2 = uh_q[1];

endmodule

// ===== rtl/iirlhp_mac.sv =====
// ----------------------------------------------------------------------------
// iirlhp_mac
// Sum of products for the selected mode, with rounding and saturation.
// ----------------------------------------------------------------------------
module iirlhp_mac (
  input  iirlhp_pkg::cfg_t                    cfg_i,
  input  iirlhp_pkg::taps_t                   taps_i,
  input  logic signed [iirlhp_pkg::SAMPLE_W-1:0] x_i,
  output logic signed [iirlhp_pkg::HIST_W-1:0]   y_hist_o,
  output logic signed [iirlhp_pkg::SAMPLE_W-1:0] sample_o
);
  import iirlhp_pkg::*;

  localparam logic signed [ACC_W-1:0]  RND_ACC = ACC_W'(1) << (COEF_FRAC_BITS - 1);
  localparam logic signed [HIST_W:0]   RND_OUT = (HIST_W + 1)'(1) << (HIST_FRAC - 1);

  logic signed [PROD_W-1:0]  pf1, pf2, pf3, pf4;
  logic signed [GPROD_W-1:0] pg0, pg1, pg2;
  logic signed [ACC_W-1:0]   f1, f2, f3, f4, g0, g1, g2;
  logic signed [ACC_W-1:0]   t1, t2, t3, t4, g;
  logic signed [ACC_W-1:0]   acc, acc_rnd, acc_shr;
  logic [ACC_W-HIST_W:0]     acc_hi;
  logic signed [HIST_W-1:0]  y_sat;
  logic signed [HIST_W:0]    o_rnd, o_shr;
  logic [HIST_W-SAMPLE_W+1:0] o_hi;

  // Parallel products on the feedback and feedforward taps.
  assign pf1 = cfg_i.fb1 * taps_i.y1;
  assign pf2 = cfg_i.fb2 * taps_i.y2;
  assign pf3 = cfg_i.fb3 * taps_i.y3;
  assign pf4 = cfg_i.fb4 * taps_i.y4;
  assign pg0 = cfg_i.ff0 * x_i;
  assign pg1 = cfg_i.ff1 * taps_i.u1;
  assign pg2 = cfg_i.ff2 * taps_i.u2;

  // Sign-extend the products to the accumulator width.
  assign f1 = {{(ACC_W-PROD_W){pf1[PROD_W-1]}}, pf1};
  assign f2 = {{(ACC_W-PROD_W){pf2[PROD_W-1]}}, pf2};
  assign f3 = {{(ACC_W-PROD_W){pf3[PROD_W-1]}}, pf3};
  assign f4 = {{(ACC_W-PROD_W){pf4[PROD_W-1]}}, pf4};
  assign g0 = {{(ACC_W-GPROD_W){pg0[GPROD_W-1]}}, pg0};
  assign g1 = {{(ACC_W-GPROD_W){pg1[GPROD_W-1]}}, pg1};
  assign g2 = {{(ACC_W-GPROD_W){pg2[GPROD_W-1]}}, pg2};

  // Select terms and signs per mode. Low-pass feedback signs alternate.
  always_comb begin
    t1 = '0;
    t2 = '0;
    t3 = '0;
    t4 = '0;
    g  = '0;
    unique case (cfg_i.mode)
      MODE_LP1: begin
        t1 = f1;
        g  = g0;
      end
      MODE_LP2: begin
        t1 = f1;
        t2 = -f2;
        g  = g0;
      end
      MODE_LP3: begin
        t1 = f1;
        t2 = -f2;
        t3 = f3;
        g  = g0;
      end
      MODE_LP4: begin
        t1 = f1;
        t2 = -f2;
        t3 = f3;
        t4 = -f4;
        g  = g0;
      end
      MODE_HP1: begin
        t1 = f1;
        g  = g0 + g1;
      end
      MODE_HP2: begin
        t1 = f1;
        t2 = f2;
        g  = g0 + g1 + g2;
      end
      MODE_MUTE, MODE_PASS: begin
        g = '0;
      end
      default: begin
        g = '0;
      end
    endcase
  end

  // Feedforward terms are taken on the input aligned to the history format.
  assign acc     = t1 + t2 + t3 + t4 + (g <<< HIST_FRAC);
  assign acc_rnd = acc + RND_ACC;
  assign acc_shr = acc_rnd >>> COEF_FRAC_BITS;
  assign acc_hi  = acc_shr[ACC_W-1:HIST_W-1];

  // Saturate the rounded sum to the history width.
  always_comb begin
    if ((&acc_hi) || !(|acc_hi)) begin
      y_sat = acc_shr[HIST_W-1:0];
    end else if (acc_shr[ACC_W-1]) begin
      y_sat = {1'b1, {(HIST_W-1){1'b0}}};
    end else begin
      y_sat = {1'b0, {(HIST_W-1){1'b1}}};
    end
  end

  // Pass-through stores the input itself.
  assign y_hist_o = (cfg_i.mode == MODE_PASS) ? {x_i, {HIST_FRAC{1'b0}}} : y_sat;

  // Round the history value to an integer sample and saturate it.
  assign o_rnd = {y_hist_o[HIST_W-1], y_hist_o} + RND_OUT;
  assign o_shr = o_rnd >>> HIST_FRAC;
  assign o_hi  = o_shr[HIST_W:SAMPLE_W-1];

  always_comb begin
    if (cfg_i.mode == MODE_MUTE) begin
      sample_o = '0;
    end else if ((&o_hi) || !(|o_hi)) begin
      sample_o = o_shr[SAMPLE_W-1:0];
    end else if (o_shr[HIST_W]) begin
      sample_o = {1'b1, {(SAMPLE_W-1){1'b0}}};
    end else begin
      sample_o = {1'b0, {(SAMPLE_W-1){1'b1}}};
    end
  end

endmodule

// ===== rtl/iir_low_high_pass_filter.sv =====
// ----------------------------------------------------------------------------
// iir_low_high_pass_filter
// Order 1 to 4 low-pass, order 1 or 2 high-pass IIR filter for 16-bit audio.
//
//   Channel   Direction  Handshake              Payload
//   input     in         in_valid_i/in_ready_o  sample_in_i   (16 bit signed)
//   output    out        out_valid_o/out_ready_i sample_out_o (16 bit signed)
//   config    in         cfg_we_i               cfg_idx_i, cfg_data_i
//
// One sample per cycle is taken and given unless the output stalls; a result
// passes the input register, then the result register. The rate is set by
// the combinational sum of products, fed back through the history registers.
// Reset clears the history, sets mode to pass-through and all gains to zero.
// A stalled output holds its result; the input register keeps accepting as
// long as it can move forward into the result register.
// ----------------------------------------------------------------------------
module iir_low_high_pass_filter (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic signed [iirlhp_pkg::SAMPLE_W-1:0] sample_in_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic signed [iirlhp_pkg::SAMPLE_W-1:0] sample_out_o,
  input  logic                                   cfg_we_i,
  input  logic [iirlhp_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [iirlhp_pkg::CFG_W-1:0]           cfg_data_i
);
  import iirlhp_pkg::*;

  cfg_t                      cfg;
  taps_t                     taps;
  logic                      in_valid_q;
  logic signed [SAMPLE_W-1:0] in_sample_q;
  logic                      out_valid_q;
  logic signed [SAMPLE_W-1:0] out_sample_q;
  logic                      advance;
  logic                      push;
  logic signed [HIST_W-1:0]  y_hist;
  logic signed [SAMPLE_W-1:0] sample_res;

  // The input register moves on when the result register is free or drains.
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;
  assign push       = advance && (cfg.mode != MODE_MUTE);

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_sample_q <= sample_in_i;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_sample_q <= sample_res;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign sample_out_o = out_sample_q;

  // Configuration registers.
  iirlhp_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // Past outputs and inputs.
  iirlhp_hist u_hist (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .y_i    (y_hist),
    .x_i    (in_sample_q),
    .taps_o (taps)
  );

  // Filter arithmetic.
  iirlhp_mac u_mac (
    .cfg_i    (cfg),
    .taps_i   (taps),
    .x_i      (in_sample_q),
    .y_hist_o (y_hist),
    .sample_o (sample_res)
  );

endmodule

// ===== dv/tb_iir_low_high_pass_filter.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_iir_low_high_pass_filter
// Self-checking testbench for the low-pass / high-pass IIR filter.
//
// A cycle-free model of the filter tracks the output and input history and
// works out every filtered sample from the settings that were written. Each
// output transfer is compared with the oldest predicted sample. Directed
// tests cover the reset mode, saturation, rounding, muting and the carry of
// input history into the high-pass modes. Random traffic follows with stable
// and arbitrary coefficient sets under several idle and stall patterns.
// ----------------------------------------------------------------------------
module tb_iir_low_high_pass_filter;
  import iirlhp_pkg::*;

  localparam int     RANDOM_ITEMS   = 1080;
  localparam int     DRAIN_CYCLES   = 4;
  localparam int     WATCHDOG_LIMIT = 2000;
  localparam longint COEF_ONE       = longint'(1) << COEF_FRAC_BITS;
  localparam longint HIST_MAX       = (longint'(1) << (HIST_W - 1)) - 1;
  localparam longint HIST_MIN       = -(longint'(1) << (HIST_W - 1));
  localparam longint SAMPLE_MAX     = (longint'(1) << (SAMPLE_W - 1)) - 1;
  localparam longint SAMPLE_MIN     = -(longint'(1) << (SAMPLE_W - 1));
  localparam logic signed [COEF_W-1:0] COEF_MAX  = {1'b0, {(COEF_W-1){1'b1}}};
  localparam logic signed [COEF_W-1:0] COEF_MIN  = {1'b1, {(COEF_W-1){1'b0}}};
  localparam logic signed [COEF_W-1:0] COEF_HALF = COEF_W'(COEF_ONE / 2);

  logic                       clk_i;
  logic                       rst_ni;
  logic                       in_valid_i;
  logic                       in_ready_o;
  logic signed [SAMPLE_W-1:0] sample_in_i;
  logic                       out_valid_o;
  logic                       out_ready_i;
  logic signed [SAMPLE_W-1:0] sample_out_o;
  logic                       cfg_we_i;
  logic [CFG_IDX_W-1:0]       cfg_idx_i;
  logic [CFG_W-1:0]           cfg_data_i;

  // Filter model state: settings, output history in Q16.8, past inputs.
  mode_e  cur_mode;
  longint fb1_gain, fb2_gain, fb3_gain, fb4_gain;
  longint ff0_gain, ff1_gain, ff2_gain;
  longint y_hist[HISTORY_DEPTH];
  longint x_hist[2];

  // Predicted output samples, oldest first.
  logic signed [SAMPLE_W-1:0] filtered_queue[$];
  logic signed [SAMPLE_W-1:0] want_sample;

  int       send_idle_pct   = 0;
  int       recv_stall_pct  = 0;
  int       error_count     = 0;
  int       samples_sent    = 0;
  int       results_checked = 0;
  int       settings_loaded = 0;
  int       stall_cycles    = 0;
  logic     xfer_seen       = 1'b0;
  bit [7:0] modes_seen      = '0;

  iir_low_high_pass_filter dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .sample_in_i (sample_in_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sample_out_o(sample_out_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Clip a value to a signed range.
  function automatic longint saturate(input longint v, input longint lo, input longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // Advance the filter model by one input sample and return the output sample.
  function automatic logic signed [SAMPLE_W-1:0] predict_filtered_sample(
      input logic signed [SAMPLE_W-1:0] x);
    longint xv, acc, y;
    int     i;
    xv = longint'(x);
    if (cur_mode == MODE_MUTE) return '0;
    acc = 0;
    case (cur_mode)
      MODE_LP1: acc = fb1_gain * y_hist[0] + ff0_gain * xv * 256;
      MODE_LP2: acc = fb1_gain * y_hist[0] - fb2_gain * y_hist[1] + ff0_gain * xv * 256;
      MODE_LP3: acc = fb1_gain * y_hist[0] - fb2_gain * y_hist[1] + fb3_gain * y_hist[2]
                      + ff0_gain * xv * 256;
      MODE_LP4: acc = fb1_gain * y_hist[0] - fb2_gain * y_hist[1] + fb3_gain * y_hist[2]
                      - fb4_gain * y_hist[3] + ff0_gain * xv * 256;
      MODE_HP1: acc = fb1_gain * y_hist[0] + (ff0_gain * xv + ff1_gain * x_hist[0]) * 256;
      MODE_HP2: acc = fb1_gain * y_hist[0] + fb2_gain * y_hist[1]
                      + (ff0_gain * xv + ff1_gain * x_hist[0] + ff2_gain * x_hist[1]) * 256;
      default:  acc = 0;
    endcase
    // Round half up to Q16.8 and saturate, except in pass-through.
    if (cur_mode == MODE_PASS) begin
      y = xv * 256;
    end else begin
      y = (acc + (longint'(1) <<< (COEF_FRAC_BITS - 1))) >>> COEF_FRAC_BITS;
      y = saturate(y, HIST_MIN, HIST_MAX);
    end
    for (i = HISTORY_DEPTH - 1; i > 0; i--) y_hist[i] = y_hist[i-1];
    y_hist[0] = y;
    x_hist[1] = x_hist[0];
    x_hist[0] = xv;
    return SAMPLE_W'(saturate((y + (1 << (HIST_FRAC - 1))) >>> HIST_FRAC,
                              SAMPLE_MIN, SAMPLE_MAX));
  endfunction

  // Random coefficient, often scaled down so that sums stay in range.
  function automatic logic signed [COEF_W-1:0] raw_coef();
    logic signed [COEF_W-1:0] v;
    v = COEF_W'($urandom);
    return v >>> $urandom_range(0, 10);
  endfunction

  function automatic logic signed [COEF_W-1:0] to_coef(input real r);
    return COEF_W'($rtoi(r * COEF_ONE));
  endfunction

  // Setting with the given mode and all gains at zero.
  function automatic cfg_t make_setting(input mode_e m);
    cfg_t c;
    c      = '0;
    c.mode = m;
    return c;
  endfunction

  // Setting with arbitrary gains.
  function automatic cfg_t random_setting(input mode_e m);
    cfg_t c;
    c.mode = m;
    c.fb1  = raw_coef();
    c.fb2  = raw_coef();
    c.fb3  = raw_coef();
    c.fb4  = raw_coef();
    c.ff0  = raw_coef();
    c.ff1  = raw_coef();
    c.ff2  = raw_coef();
    return c;
  endfunction

  // Well-behaved filter built from a repeated real pole; gains that the
  // mode does not read keep random values.
  function automatic cfg_t stable_setting(input mode_e m);
    cfg_t c;
    real  p, g, binom, pk;
    real  taps[1:4];
    int   order, k;
    c = random_setting(m);
    p = 0.2 + 0.75 * real'($urandom_range(1000)) / 1000.0;
    if (m >= MODE_LP1 && m <= MODE_LP4) begin
      order = int'(m);
      binom = 1.0;
      pk    = 1.0;
      g     = 1.0;
      for (k = 1; k <= order; k++) begin
        binom   = binom * (order - k + 1) / k;
        pk      = pk * p;
        g       = g * (1.0 - p);
        taps[k] = binom * pk;
      end
      c.fb1 = to_coef(taps[1]);
      if (order >= 2) c.fb2 = to_coef(taps[2]);
      if (order >= 3) c.fb3 = to_coef(taps[3]);
      if (order >= 4) c.fb4 = to_coef(taps[4]);
      c.ff0 = to_coef(g);
    end else if (m == MODE_HP1) begin
      g     = (1.0 + p) / 2.0;
      c.fb1 = to_coef(p);
      c.ff0 = to_coef(g);
      c.ff1 = to_coef(-g);
    end else if (m == MODE_HP2) begin
      g     = (1.0 + p) * (1.0 + p) / 4.0;
      c.fb1 = to_coef(2.0 * p);
      c.fb2 = to_coef(-p * p);
      c.ff0 = to_coef(g);
      c.ff1 = to_coef(-2.0 * g);
      c.ff2 = to_coef(g);
    end
    return c;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] random_sample();
    logic signed [SAMPLE_W-1:0] s;
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(3))
          0:       s = SAMPLE_W'(SAMPLE_MAX);
          1:       s = SAMPLE_W'(SAMPLE_MIN);
          2:       s = '0;
          default: s = '1;
        endcase
      end
      1, 2, 3: s = SAMPLE_W'(int'($urandom_range(511)) - 256);
      default: s = SAMPLE_W'($urandom);
    endcase
    return s;
  endfunction

  task automatic reset_model();
    int i;
    cur_mode = MODE_PASS;
    fb1_gain = 0;
    fb2_gain = 0;
    fb3_gain = 0;
    fb4_gain = 0;
    ff0_gain = 0;
    ff1_gain = 0;
    ff2_gain = 0;
    for (i = 0; i < HISTORY_DEPTH; i++) y_hist[i] = 0;
    x_hist[0] = 0;
    x_hist[1] = 0;
  endtask

  // Lower valid and wait until every predicted sample has come out.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (filtered_queue.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // One register write; the model follows at the same edge.
  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    case (idx)
      REG_MODE: cur_mode = mode_e'(data[MODE_W-1:0]);
      REG_FB1:  fb1_gain = longint'($signed(data));
      REG_FB2:  fb2_gain = longint'($signed(data));
      REG_FB3:  fb3_gain = longint'($signed(data));
      REG_FB4:  fb4_gain = longint'($signed(data));
      REG_FF0:  ff0_gain = longint'($signed(data));
      REG_FF1:  ff1_gain = longint'($signed(data));
      REG_FF2:  ff2_gain = longint'($signed(data));
      default:  ;
    endcase
  endtask

  // Write a whole setting once the filter is idle.
  task automatic load_setting(input cfg_t c);
    logic [CFG_W-1:0] mode_word;
    wait_drained();
    // Bits above the mode field carry noise; only the low bits count.
    mode_word                = CFG_W'($urandom);
    mode_word[MODE_W-1:0]    = c.mode;
    write_reg(REG_MODE, mode_word);
    write_reg(REG_FB1, c.fb1);
    write_reg(REG_FB2, c.fb2);
    write_reg(REG_FB3, c.fb3);
    write_reg(REG_FB4, c.fb4);
    write_reg(REG_FF0, c.ff0);
    write_reg(REG_FF1, c.ff1);
    write_reg(REG_FF2, c.ff2);
    cfg_we_i <= 1'b0;
    settings_loaded++;
  endtask

  // Present one sample and hold it until the input transfer.
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] x);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    sample_in_i <= x;
    do @(negedge clk_i); while (!in_ready_o);
    @(posedge clk_i);
    modes_seen[cur_mode] = 1'b1;
    filtered_queue.push_back(predict_filtered_sample(x));
    samples_sent++;
  endtask

  // Reset state is pass-through with cleared history.
  task automatic test_pass_after_reset();
    send_sample(SAMPLE_W'(SAMPLE_MAX));
    send_sample(SAMPLE_W'(SAMPLE_MIN));
    send_sample('0);
    send_sample('1);
  endtask

  // Full-scale gains saturate both ways; a gain of one half shows rounding.
  task automatic test_saturation_and_rounding();
    cfg_t c;
    c     = make_setting(MODE_LP1);
    c.ff0 = COEF_MAX;
    load_setting(c);
    send_sample(SAMPLE_W'(SAMPLE_MAX));
    send_sample(SAMPLE_W'(SAMPLE_MIN));
    c.ff0 = COEF_MIN;
    load_setting(c);
    send_sample(SAMPLE_W'(SAMPLE_MIN));
    send_sample(SAMPLE_W'(SAMPLE_MAX));
    c.ff0 = COEF_HALF;
    load_setting(c);
    send_sample(SAMPLE_W'(1));
    send_sample('1);
  endtask

  // Muting gives zeros and leaves the history where it was.
  task automatic test_mute_keeps_state();
    cfg_t c;
    c = stable_setting(MODE_LP2);
    load_setting(c);
    repeat (3) send_sample(random_sample());
    c.mode = MODE_MUTE;
    load_setting(c);
    repeat (2) send_sample(random_sample());
    c.mode = MODE_LP2;
    load_setting(c);
    send_sample(random_sample());
  endtask

  // Inputs taken in pass-through feed the high-pass taps afterwards.
  task automatic test_history_into_highpass();
    load_setting(make_setting(MODE_PASS));
    send_sample(SAMPLE_W'(SAMPLE_MAX));
    send_sample(SAMPLE_W'(SAMPLE_MIN));
    load_setting(stable_setting(MODE_HP2));
    repeat (2) send_sample(random_sample());
  endtask

  // The remaining filter orders.
  task automatic test_remaining_modes();
    load_setting(stable_setting(MODE_LP3));
    repeat (2) send_sample(random_sample());
    load_setting(stable_setting(MODE_LP4));
    repeat (2) send_sample(random_sample());
    load_setting(stable_setting(MODE_HP1));
    repeat (2) send_sample(random_sample());
  endtask

  // Bursts under random settings, one idle pattern per quarter of the run.
  task automatic test_random_traffic();
    int    idle_plan[4][2] = '{'{0, 0}, '{79, 0}, '{0, 79}, '{22, 22}};
    int    phase_goal;
    int    ph;
    mode_e m;
    for (ph = 0; ph < 4; ph++) begin
      send_idle_pct  = idle_plan[ph][0];
      recv_stall_pct = idle_plan[ph][1];
      phase_goal     = samples_sent + RANDOM_ITEMS / 4;
      while (samples_sent < phase_goal) begin
        m = mode_e'($urandom_range(7));
        if ($urandom_range(9) < 7) load_setting(stable_setting(m));
        else load_setting(random_setting(m));
        repeat ($urandom_range(10, 50)) send_sample(random_sample());
      end
    end
  endtask

  // Output readiness, redrawn every cycle.
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Check each output transfer against the oldest prediction.
  always @(negedge clk_i) begin
    xfer_seen = rst_ni && ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i));
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (filtered_queue.size() == 0) begin
        $display("%0t: output sample %0d with no input waiting", $time, sample_out_o);
        error_count++;
      end else begin
        want_sample = filtered_queue.pop_front();
        if (sample_out_o !== want_sample) begin
          $display("%0t: sample_out mismatch: expected %0d, actual %0d",
                   $time, want_sample, sample_out_o);
          error_count++;
        end
      end
      results_checked++;
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk_i) begin
    if (xfer_seen) stall_cycles = 0;
    else stall_cycles++;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, stall_cycles);
      $display("iir_low_high_pass_filter test failed");
      $finish;
    end
  end

  // Test sequence.
  initial begin
    in_valid_i  <= 1'b0;
    sample_in_i <= '0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= REG_MODE;
    cfg_data_i  <= '0;
    rst_ni      <= 1'b0;
    reset_model();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_pass_after_reset();
    test_saturation_and_rounding();
    test_mute_keeps_state();
    test_history_into_highpass();
    test_remaining_modes();
    test_random_traffic();
    wait_drained();

    if (filtered_queue.size() != 0) begin
      $display("%0t: %0d predicted samples never came out", $time, filtered_queue.size());
      error_count++;
    end
    $display("Run covered %0d input samples under %0d filter settings, %0d outputs checked.",
             samples_sent, settings_loaded, results_checked);
    $display("Modes used, one bit per mode with mute as bit 0: %08b", modes_seen);
    if (error_count == 0) begin
      $display("iir_low_high_pass_filter test passed");
    end else begin
      $display("iir_low_high_pass_filter test failed");
    end
    $finish;
  end

endmodule
